>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the core modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> rtl/core/rrsc_pkg.sv
// ----------------------------------------------------------------------------
// rrsc_pkg
// Types, constants and colour scale of the radial run segmenter core.
// ----------------------------------------------------------------------------
package rrsc_pkg;

    // default build parameters
    localparam int MAX_GATES_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;

    // register reset values
    localparam logic [7:0]  MIN_CODE_RST    = 8'd68;
    localparam logic [15:0] GATE_EXTENT_RST = 16'd250;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MIN_CODE    = 1'b0,
        CFG_GATE_EXTENT = 1'b1
    } cfg_reg_t;

    // colour scale: thresholds in half-dB above which a bucket starts
    localparam int NUM_BUCKETS = 9;
    localparam int BKT_W       = 4;
    localparam logic [BKT_W-1:0] BKT_OFF_SCALE = 4'd0;
    localparam logic [BKT_W-1:0] BKT_WHITE     = 4'd1;
    localparam logic [BKT_W-1:0] BKT_WIDE      = 4'd8;
    localparam logic signed [8:0] THR_HALF [NUM_BUCKETS] =
        '{9'sd160, 9'sd140, 9'sd120, 9'sd100, 9'sd80, 9'sd60, 9'sd40, 9'sd20, -9'sd20};
    // code offset: half-dB value h = code - 66
    localparam logic signed [8:0] CODE_OFFSET = 9'sd66;

    // per bucket: high r,g,b then low r,g,b
    localparam logic [7:0] PALETTE [NUM_BUCKETS][6] = '{
        '{8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },
        '{8'd255, 8'd0,   8'd255, 8'd128, 8'd0,   8'd128},
        '{8'd255, 8'd0,   8'd0,   8'd160, 8'd0,   8'd0  },
        '{8'd255, 8'd255, 8'd0,   8'd255, 8'd128, 8'd0  },
        '{8'd0,   8'd255, 8'd0,   8'd0,   8'd128, 8'd0  },
        '{8'd64,  8'd128, 8'd255, 8'd32,  8'd64,  8'd128},
        '{8'd164, 8'd164, 8'd255, 8'd100, 8'd100, 8'd192},
        '{8'd64,  8'd64,  8'd64,  8'd164, 8'd164, 8'd164}
    };

    // bucket spans in half-dB
    localparam logic [5:0] SPAN_NARROW = 6'd20;
    localparam logic [5:0] SPAN_WIDE   = 6'd40;

    // reciprocal for division by 20 (shift 16) and by 40 (shift 17)
    localparam logic [11:0] RECIP_20 = 12'd3277;
    localparam int NUM_W = 14;

    // input item
    typedef struct packed {
        logic [7:0]  gate_code;
        logic        first_of_radial;
        logic        last_of_radial;
        logic [9:0]  azimuth_number;
        logic [15:0] first_distance;
        logic [15:0] gate_spacing;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [9:0]  seg_azimuth;
        logic [26:0] range_begin;
        logic [27:0] range_end;
        logic [7:0]  level_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        off_scale;
    } out_item_t;

    // closed run handed from front to back, without gate indexes
    typedef struct packed {
        logic [9:0]  azimuth;
        logic [15:0] first_distance;
        logic [15:0] gate_spacing;
        logic [7:0]  level_code;
    } seg_info_t;

endpackage

>>> rtl/core/radial_run_segmenter_colorizer_core.sv
// ----------------------------------------------------------------------------
// radial_run_segmenter_colorizer_core
// Groups gate codes of a radial into runs and emits coloured range segments.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item_t gate item
//   out      output     out_valid / out_stall out_item_t segment
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One gate accepted per cycle while in_stall is low; the run compare sits in the front,
// the range multiplies and colour division in a two-register back pipeline.
// A segment passes through the queue, the stage a register and the output register.
// in_stall rises only while the four-entry queue between front and back is full.
// Reset clears run state, queue and valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radial_run_segmenter_colorizer_core
    import rrsc_pkg::*;
#(
    parameter int MAX_GATES   = MAX_GATES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  in_item_t    in_data,
    output logic        in_stall,
    output logic        out_valid,
    output out_item_t   out_data,
    input  logic        out_stall,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_reg_t    cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int GW = $clog2(MAX_GATES);
    localparam int QW = $bits(seg_info_t) + 2 * GW;

    logic [7:0]    min_code_reg;
    logic [15:0]   gate_extent_reg;

    logic          push_valid;
    seg_info_t     push_info;
    logic [GW-1:0] push_start;
    logic [GW-1:0] push_end;
    logic          queue_full;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    seg_info_t     pop_info;
    logic [GW-1:0] pop_start;
    logic [GW-1:0] pop_end;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_code_reg    <= MIN_CODE_RST;
            gate_extent_reg <= GATE_EXTENT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_CODE:    min_code_reg    <= cfg_data[7:0];
                CFG_GATE_EXTENT: gate_extent_reg <= cfg_data;
                default:         min_code_reg    <= min_code_reg;
            endcase
        end
    end

    // run tracking
    rrsc_front #(
        .MAX_GATES (MAX_GATES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .min_code   (min_code_reg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_info  (push_info),
        .push_start (push_start),
        .push_end   (push_end)
    );

    // closed runs waiting for formatting
    rrsc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  ({push_info, push_start, push_end}),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    assign {pop_info, pop_start, pop_end} = pop_data;

    // segment formatting
    rrsc_back #(
        .MAX_GATES (MAX_GATES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_info    (pop_info),
        .pop_start   (pop_start),
        .pop_end     (pop_end),
        .pop_ready   (pop_ready),
        .gate_extent (gate_extent_reg),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .out_stall   (out_stall)
    );

endmodule

>>> rtl/core/rrsc_queue.sv
// ----------------------------------------------------------------------------
// rrsc_queue
// Small register queue between run detection and segment formatting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrsc_queue
    import rrsc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    input  logic             pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // pointer and fill count update, wrap at depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push_valid && full, "push into full queue")
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH), "queue count past depth")
    `ASSERT_ALWAYS(a_count_track, clk, rst_n, do_push && !do_pop |=> count_reg != '0, "push lost")

endmodule

>>> rtl/core/rrsc_front.sv
// ----------------------------------------------------------------------------
// rrsc_front
// Gate intake: tracks the open run and classifies each gate as run close.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrsc_front
    import rrsc_pkg::*;
#(
    parameter int MAX_GATES = MAX_GATES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  in_item_t                       in_data,
    output logic                           in_stall,
    input  logic [7:0]                     min_code,
    input  logic                           queue_full,
    output logic                           push_valid,
    output seg_info_t                      push_info,
    output logic [$clog2(MAX_GATES)-1:0]   push_start,
    output logic [$clog2(MAX_GATES)-1:0]   push_end
);

    localparam int GW = $clog2(MAX_GATES);

    logic [7:0]    run_value_reg, run_value_next;
    logic [GW-1:0] run_start_reg, run_start_next;
    logic [GW-1:0] gate_index_reg, gate_index_next;
    logic [GW-1:0] gate_k;
    logic          accept;
    logic          run_close;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // saturating next gate index
    assign gate_k = (gate_index_reg < GW'(MAX_GATES - 1)) ? gate_index_reg + 1'b1
                                                          : GW'(MAX_GATES - 1);

    // run closes on a code change or at the last gate
    assign run_close = (in_data.gate_code != run_value_reg) || in_data.last_of_radial;

    // run state update and emit decision
    always_comb
    begin
        run_value_next  = run_value_reg;
        run_start_next  = run_start_reg;
        gate_index_next = gate_index_reg;
        push_valid      = 1'b0;
        if (accept)
        begin
            if (in_data.first_of_radial)
            begin
                run_value_next  = in_data.gate_code;
                run_start_next  = '0;
                gate_index_next = '0;
            end
            else
            begin
                gate_index_next = gate_k;
                if (run_close)
                begin
                    push_valid     = (run_value_reg >= min_code);
                    run_start_next = gate_k;
                    run_value_next = in_data.gate_code;
                end
            end
        end
    end

    // segment payload for the back end
    assign push_info.azimuth        = in_data.azimuth_number;
    assign push_info.first_distance = in_data.first_distance;
    assign push_info.gate_spacing   = in_data.gate_spacing;
    assign push_info.level_code     = run_value_reg;
    assign push_start               = run_start_reg;
    assign push_end                 = gate_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= '0;
            run_start_reg  <= '0;
            gate_index_reg <= '0;
        end
        else
        begin
            run_value_reg  <= run_value_next;
            run_start_reg  <= run_start_next;
            gate_index_reg <= gate_index_next;
        end
    end

    `ASSERT_NEVER(a_index_sat, clk, rst_n, gate_index_reg > GW'(MAX_GATES - 1), "gate index past limit")
    `ASSERT_NEVER(a_start_order, clk, rst_n, run_start_reg > gate_index_reg, "run starts after index")
    `ASSERT_ALWAYS(a_push_on_close, clk, rst_n, push_valid |-> accept && run_close, "spurious segment")

endmodule

>>> rtl/core/rrsc_back.sv
// ----------------------------------------------------------------------------
// rrsc_back
// Segment formatting: range products, colour interpolation, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrsc_back
    import rrsc_pkg::*;
#(
    parameter int MAX_GATES = MAX_GATES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    input  seg_info_t                      pop_info,
    input  logic [$clog2(MAX_GATES)-1:0]   pop_start,
    input  logic [$clog2(MAX_GATES)-1:0]   pop_end,
    output logic                           pop_ready,
    input  logic [15:0]                    gate_extent,
    output logic                           out_valid,
    output out_item_t                      out_data,
    input  logic                           out_stall
);

    localparam int GW = $clog2(MAX_GATES);
    localparam int PW = 16 + GW;
    localparam int SW = (PW + 2 > 28) ? PW + 2 : 28;

    // stage a registers
    logic             a_valid_reg;
    seg_info_t        a_info_reg;
    logic [PW-1:0]    a_prod_b_reg;
    logic [PW-1:0]    a_prod_e_reg;
    logic [NUM_W-1:0] a_num_reg [3];
    logic             a_wide_reg;
    logic             a_black_reg;
    logic             a_off_reg;

    // output register
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic             out_adv;
    logic             a_adv;
    logic             take;

    logic signed [8:0] half_db;
    logic [BKT_W-1:0]  bkt;
    logic              bkt_hit;
    logic [5:0]        span;
    logic [5:0]        delta;
    logic [NUM_W-1:0]  num [3];

    logic [SW-1:0]     sum_b;
    logic [SW-1:0]     sum_e;
    logic [25:0]       quo_prod [3];
    logic [7:0]        comp [3];
    logic              out_rgb_zero;

    // pipeline advance
    assign out_adv   = !out_valid_reg || !out_stall;
    assign a_adv     = !a_valid_reg || out_adv;
    assign take      = pop_valid && a_adv;
    assign pop_ready = a_adv;

    // bucket search: first threshold below the half-dB value
    assign half_db = $signed({1'b0, pop_info.level_code}) - CODE_OFFSET;

    always_comb
    begin
        bkt     = '0;
        bkt_hit = 1'b0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (half_db > THR_HALF[i])
            begin
                bkt     = BKT_W'(i);
                bkt_hit = 1'b1;
            end
        end
    end

    // interpolation numerators hi*(span-d) + lo*d, white bucket keeps its high colour
    always_comb
    begin
        span  = (bkt == BKT_WIDE) ? SPAN_WIDE : SPAN_NARROW;
        delta = (bkt == BKT_WHITE) ? 6'd0 : 6'(half_db - THR_HALF[bkt]);
        for (int c = 0; c < 3; c++)
        begin
            num[c] = NUM_W'(PALETTE[bkt][c]) * NUM_W'(span - delta)
                   + NUM_W'(PALETTE[bkt][c + 3]) * NUM_W'(delta);
        end
    end

    // stage a: products and numerators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_info_reg   <= pop_info;
            a_prod_b_reg <= pop_info.gate_spacing * pop_start;
            a_prod_e_reg <= pop_info.gate_spacing * pop_end;
            for (int c = 0; c < 3; c++)
            begin
                a_num_reg[c] <= num[c];
            end
            a_wide_reg  <= (bkt == BKT_WIDE);
            a_black_reg <= !bkt_hit || (bkt == BKT_OFF_SCALE);
            a_off_reg   <= bkt_hit && (bkt == BKT_OFF_SCALE);
        end
    end

    // stage b: range sums and reciprocal division
    assign sum_b = SW'(a_info_reg.first_distance) + SW'(a_prod_b_reg);
    assign sum_e = SW'(a_info_reg.first_distance) + SW'(a_prod_e_reg) + SW'(gate_extent);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            quo_prod[c] = a_num_reg[c] * RECIP_20;
            if (a_black_reg)
            begin
                comp[c] = '0;
            end
            else if (a_wide_reg)
            begin
                comp[c] = quo_prod[c][24:17];
            end
            else
            begin
                comp[c] = quo_prod[c][23:16];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && a_valid_reg)
        begin
            out_data_reg.seg_azimuth <= a_info_reg.azimuth;
            out_data_reg.range_begin <= sum_b[26:0];
            out_data_reg.range_end   <= sum_e[27:0];
            out_data_reg.level_code  <= a_info_reg.level_code;
            out_data_reg.red         <= comp[0];
            out_data_reg.green       <= comp[1];
            out_data_reg.blue        <= comp[2];
            out_data_reg.off_scale   <= a_off_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // black output colour
    assign out_rgb_zero = (out_data_reg.red == '0) && (out_data_reg.green == '0)
                       && (out_data_reg.blue == '0);

    `ASSERT_ALWAYS(a_off_black, clk, rst_n, out_valid_reg && out_data_reg.off_scale |-> out_rgb_zero, "off-scale not black")
    `ASSERT_ALWAYS(a_hold_stage, clk, rst_n, a_valid_reg && !a_adv |=> a_valid_reg, "stage a dropped an item")
    `ASSERT_ALWAYS(a_no_bubble_fill, clk, rst_n, out_adv && !a_valid_reg |=> !out_valid_reg, "output filled from empty stage")

endmodule
